// ===== hw/rtl/hybrid_local_bimode_branch_predictor_assert.svh =====
// Assertion macros used by the predictor's top level.
// Each macro samples on the rising edge of clk and is disabled while rst_n is low.
`ifndef HYBRID_LOCAL_BIMODE_BRANCH_PREDICTOR_ASSERT_SVH
`define HYBRID_LOCAL_BIMODE_BRANCH_PREDICTOR_ASSERT_SVH

// Checks a property given in full, with its own implication and delays.
`define HLBP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("hlbp assertion failed");

// Checks that cons holds in the cycle after en.
`define HLBP_ASSERT_NEXT(label, en, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (en) |=> (cons)) \
    else $error("hlbp assertion failed");

`endif

// ===== hw/rtl/hlbp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hlbp_pkg;

  // Default table geometry.
  localparam int DEF_PC_INDEX_BITS    = 10;
  localparam int DEF_LOCAL_HIST_BITS  = 10;
  localparam int DEF_GLOBAL_HIST_BITS = 13;
  localparam int DEF_CHOOSER_BITS     = 12;

  localparam int PC_W   = 32;
  localparam int QDEPTH = 2;

  // Reset states of the 2-bit counters.
  localparam logic [1:0] WN  = 2'd1;
  localparam logic [1:0] WT  = 2'd2;
  localparam logic [1:0] WNG = 2'd1;
  localparam logic [1:0] WG  = 2'd1;

  // One request word as it sits in the queue.
  typedef struct packed {
    logic            action;
    logic [PC_W-1:0] pc;
    logic            outcome;
  } req_t;

  // Head of the queue as the back end sees it.
  typedef struct packed {
    logic valid;
    req_t word;
  } head_t;

  // Status from the back end to the front end.
  typedef struct packed {
    logic take;
    logic clearing;
  } bk_stat_t;

  // A counter predicts taken in its two upper states.
  function automatic logic ctr_read(input logic [1:0] c);
    return c[1];
  endfunction

  // Saturating move of a 2-bit counter toward up or down.
  function automatic logic [1:0] ctr_move(input logic [1:0] c, input logic up);
    logic [1:0] r;
    r = c;
    if (up) begin
      if (c != 2'd3) r = c + 2'd1;
    end else begin
      if (c != 2'd0) r = c - 2'd1;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/hlbp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hlbp_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic                   in_action,
  input  logic [31:0]            in_pc,
  input  logic                   in_outcome,
  input  hlbp_pkg::bk_stat_t     bk_stat,
  output logic                   busy,
  output hlbp_pkg::head_t        head
);
  import hlbp_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  req_t             fifo_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  logic             pop;

  // The queue refuses words while full or while the tables are being cleared.
  assign busy = (count_r == CNT_W'(QDEPTH)) || bk_stat.clearing;
  assign push = start && !busy;
  assign pop  = bk_stat.take;

  assign head.valid = (count_r != '0);
  assign head.word  = fifo_r[rd_ptr_r];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_r[wr_ptr_r] <= '{action: in_action, pc: in_pc, outcome: in_outcome};
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/hlbp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hlbp_back #(
  parameter int PC_INDEX_BITS    = hlbp_pkg::DEF_PC_INDEX_BITS,
  parameter int LOCAL_HIST_BITS  = hlbp_pkg::DEF_LOCAL_HIST_BITS,
  parameter int GLOBAL_HIST_BITS = hlbp_pkg::DEF_GLOBAL_HIST_BITS,
  parameter int CHOOSER_BITS     = hlbp_pkg::DEF_CHOOSER_BITS
) (
  input  logic               clk,
  input  logic               rst_n,
  input  hlbp_pkg::head_t    head,
  output hlbp_pkg::bk_stat_t bk_stat,
  output logic               out_valid,
  output logic               out_prediction
);
  import hlbp_pkg::*;

  localparam int PIB = PC_INDEX_BITS;
  localparam int LHB = LOCAL_HIST_BITS;
  localparam int GHB = GLOBAL_HIST_BITS;
  localparam int CHB = CHOOSER_BITS;

  localparam int LH_DEPTH = 1 << PIB;
  localparam int LC_DEPTH = 1 << LHB;
  localparam int GB_DEPTH = 1 << GHB;
  localparam int CH_DEPTH = 1 << CHB;

  localparam int MAX_A = (PIB > LHB) ? PIB : LHB;
  localparam int MAX_B = (GHB > CHB) ? GHB : CHB;
  localparam int CLR_W = (MAX_A > MAX_B) ? MAX_A : MAX_B;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_CTR,
    ST_EXEC
  } state_t;

  state_t           state_r;
  logic [CLR_W-1:0] clr_addr_r;
  logic [GHB-1:0]   ghist_r;
  req_t             req_r;
  logic [PIB-1:0]   li_r;
  logic [GHB-1:0]   gi_r;
  logic [CHB-1:0]   hi_r;
  logic             out_valid_r;
  logic             out_pred_r;

  // Tables.
  logic [LHB-1:0] lh_mem  [LH_DEPTH];
  logic [1:0]     lc_mem  [LC_DEPTH];
  logic [1:0]     nt_mem  [GB_DEPTH];
  logic [1:0]     tk_mem  [GB_DEPTH];
  logic [1:0]     ch_mem  [CH_DEPTH];
  logic [1:0]     sel_mem [GB_DEPTH];

  // Registered read data.
  logic [LHB-1:0] lh_q;
  logic [1:0]     lc_q;
  logic [1:0]     nt_q;
  logic [1:0]     tk_q;
  logic [1:0]     ch_q;
  logic [1:0]     sel_q;

  // Write ports.
  logic           lh_we,  lc_we,  nt_we,  tk_we,  ch_we,  sel_we;
  logic [PIB-1:0] lh_wa;
  logic [LHB-1:0] lc_wa;
  logic [GHB-1:0] nt_wa, tk_wa, sel_wa;
  logic [CHB-1:0] ch_wa;
  logic [LHB-1:0] lh_wd;
  logic [1:0]     lc_wd, nt_wd, tk_wd, ch_wd, sel_wd;

  logic           take;
  logic [PIB-1:0] li_rd;
  logic [GHB-1:0] gi_rd;
  logic [CHB-1:0] hi_rd;

  logic           lp, use_tk, gp, use_local, pred, t, train;
  logic           ch_upd, sel_up, sel_dn;
  logic [LHB:0]   lh_cat;
  logic [GHB:0]   gh_cat;
  logic [LHB-1:0] lh_shift;
  logic [GHB-1:0] gh_shift;

  // A new word is taken only when the previous one has fully written back.
  assign take             = (state_r == ST_IDLE) && head.valid;
  assign bk_stat.take     = take;
  assign bk_stat.clearing = (state_r == ST_CLEAR);

  // Table indexes of the word at the queue head.
  assign li_rd = head.word.pc[PIB-1:0];
  assign gi_rd = ghist_r ^ head.word.pc[GHB-1:0];
  assign hi_rd = head.word.pc[CHB-1:0];

  // Prediction and update decisions from the registered reads.
  assign t         = req_r.outcome;
  assign lp        = ctr_read(lc_q);
  assign use_tk    = ctr_read(ch_q);
  assign gp        = use_tk ? ctr_read(tk_q) : ctr_read(nt_q);
  assign use_local = ctr_read(sel_q);
  assign pred      = use_local ? lp : gp;
  assign train     = (state_r == ST_EXEC) && req_r.action;

  // The chooser holds when the chosen bank was right against its own bias.
  assign ch_upd = use_tk ? !((gp == t) && !gp) : !((gp == t) && gp);
  assign sel_up = (lp == t) && (gp != t);
  assign sel_dn = (lp != t) && (gp == t);

  // Shift the outcome into both histories.
  assign lh_cat   = {lh_q, t};
  assign lh_shift = lh_cat[LHB-1:0];
  assign gh_cat   = {ghist_r, t};
  assign gh_shift = gh_cat[GHB-1:0];

  // Write port selection: the clearing sweep, or a train write-back.
  always_comb begin
    lh_we  = 1'b0;
    lc_we  = 1'b0;
    nt_we  = 1'b0;
    tk_we  = 1'b0;
    ch_we  = 1'b0;
    sel_we = 1'b0;
    lh_wa  = clr_addr_r[PIB-1:0];
    lc_wa  = clr_addr_r[LHB-1:0];
    nt_wa  = clr_addr_r[GHB-1:0];
    tk_wa  = clr_addr_r[GHB-1:0];
    ch_wa  = clr_addr_r[CHB-1:0];
    sel_wa = clr_addr_r[GHB-1:0];
    lh_wd  = '0;
    lc_wd  = WN;
    nt_wd  = WN;
    tk_wd  = WT;
    ch_wd  = WNG;
    sel_wd = WG;
    if (state_r == ST_CLEAR) begin
      lh_we  = 1'b1;
      lc_we  = 1'b1;
      nt_we  = 1'b1;
      tk_we  = 1'b1;
      ch_we  = 1'b1;
      sel_we = 1'b1;
    end else if (train) begin
      lh_we  = 1'b1;
      lh_wa  = li_r;
      lh_wd  = lh_shift;
      lc_we  = 1'b1;
      lc_wa  = lh_q;
      lc_wd  = ctr_move(lc_q, t);
      nt_we  = !use_tk;
      nt_wa  = gi_r;
      nt_wd  = ctr_move(nt_q, t);
      tk_we  = use_tk;
      tk_wa  = gi_r;
      tk_wd  = ctr_move(tk_q, t);
      ch_we  = ch_upd;
      ch_wa  = hi_r;
      ch_wd  = ctr_move(ch_q, t);
      sel_we = sel_up || sel_dn;
      sel_wa = gi_r;
      sel_wd = ctr_move(sel_q, sel_up);
    end
  end

  // Local history table: read on take.
  always_ff @(posedge clk) begin
    if (lh_we) lh_mem[lh_wa] <= lh_wd;
    if (take) lh_q <= lh_mem[li_rd];
  end

  // Local counter table: read once the history has arrived.
  always_ff @(posedge clk) begin
    if (lc_we) lc_mem[lc_wa] <= lc_wd;
    if (state_r == ST_RD_CTR) lc_q <= lc_mem[lh_q];
  end

  // Not-taken-biased bank.
  always_ff @(posedge clk) begin
    if (nt_we) nt_mem[nt_wa] <= nt_wd;
    if (take) nt_q <= nt_mem[gi_rd];
  end

  // Taken-biased bank.
  always_ff @(posedge clk) begin
    if (tk_we) tk_mem[tk_wa] <= tk_wd;
    if (take) tk_q <= tk_mem[gi_rd];
  end

  // Bank chooser.
  always_ff @(posedge clk) begin
    if (ch_we) ch_mem[ch_wa] <= ch_wd;
    if (take) ch_q <= ch_mem[hi_rd];
  end

  // Local/global selector.
  always_ff @(posedge clk) begin
    if (sel_we) sel_mem[sel_wa] <= sel_wd;
    if (take) sel_q <= sel_mem[gi_rd];
  end

  // Sequencer: clearing sweep, take, counter read, execute.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      ghist_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLEAR: begin
          clr_addr_r <= clr_addr_r + 1'b1;
          if (clr_addr_r == '1) state_r <= ST_IDLE;
        end
        ST_IDLE: begin
          if (take) begin
            req_r   <= head.word;
            li_r    <= li_rd;
            gi_r    <= gi_rd;
            hi_r    <= hi_rd;
            state_r <= ST_RD_CTR;
          end
        end
        ST_RD_CTR: begin
          state_r <= ST_EXEC;
        end
        ST_EXEC: begin
          out_valid_r <= 1'b1;
          out_pred_r  <= pred;
          if (req_r.action) ghist_r <= gh_shift;
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_prediction = out_pred_r;

endmodule

`default_nettype wire

// ===== hw/rtl/hybrid_local_bimode_branch_predictor.sv =====
// An accepted word is taken from the queue, its tables are read, and out_valid is registered as
// it executes. No new word is taken until the last has written back, due to the dependent
// history-then-counter reads and the table write-back; a two-word queue buffers new requests.
// Reset: synchronous active-low; afterwards a clearing pass over 2^max(index widths) addresses
// (8192 at the defaults) sets every table, with busy high throughout. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module hybrid_local_bimode_branch_predictor #(
  parameter int PC_INDEX_BITS    = hlbp_pkg::DEF_PC_INDEX_BITS,
  parameter int LOCAL_HIST_BITS  = hlbp_pkg::DEF_LOCAL_HIST_BITS,
  parameter int GLOBAL_HIST_BITS = hlbp_pkg::DEF_GLOBAL_HIST_BITS,
  parameter int CHOOSER_BITS     = hlbp_pkg::DEF_CHOOSER_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_action,
  input  logic [31:0] in_pc,
  input  logic        in_outcome,
  output logic        out_valid,
  output logic        out_prediction
);
  import hlbp_pkg::*;

  head_t    head;
  bk_stat_t bk_stat;

  // Front end: accepts request words into the queue.
  hlbp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_action  (in_action),
    .in_pc      (in_pc),
    .in_outcome (in_outcome),
    .bk_stat    (bk_stat),
    .busy       (busy),
    .head       (head)
  );

  // Back end: table lookup, prediction and training.
  hlbp_back #(
    .PC_INDEX_BITS    (PC_INDEX_BITS),
    .LOCAL_HIST_BITS  (LOCAL_HIST_BITS),
    .GLOBAL_HIST_BITS (GLOBAL_HIST_BITS),
    .CHOOSER_BITS     (CHOOSER_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .bk_stat        (bk_stat),
    .out_valid      (out_valid),
    .out_prediction (out_prediction)
  );

  // Checks on the sequencing of the back end.
  `include "hybrid_local_bimode_branch_predictor_assert.svh"

  `HLBP_ASSERT_NEXT(a_no_back_to_back_strobe, out_valid, !out_valid)
  `HLBP_ASSERT(a_no_strobe_while_clearing, bk_stat.clearing |-> !out_valid)
  `HLBP_ASSERT(a_take_gives_result, bk_stat.take |-> ##3 out_valid)
  `HLBP_ASSERT(a_no_take_while_clearing, bk_stat.clearing |-> !bk_stat.take)

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import hlbp_pkg::*;

  // Table geometry of the block under test.
  localparam int PCI_W = DEF_PC_INDEX_BITS;
  localparam int LH_W  = DEF_LOCAL_HIST_BITS;
  localparam int GH_W  = DEF_GLOBAL_HIST_BITS;
  localparam int CH_W  = DEF_CHOOSER_BITS;

  // Request and direction codes.
  localparam logic ACT_PREDICT = 1'b0;
  localparam logic ACT_TRAIN   = 1'b1;
  localparam logic NOT_TAKEN   = 1'b0;
  localparam logic TAKEN       = 1'b1;

  localparam int RANDOM_WORDS = 1100;
  localparam int CALM_TAIL    = 150;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 200000;

  logic            clk            = 1'b0;
  logic            rst_n          = 1'b0;
  logic            start          = 1'b0;
  logic            in_action      = 1'b0;
  logic [PC_W-1:0] in_pc          = '0;
  logic            in_outcome     = 1'b0;
  logic            busy;
  logic            out_valid;
  logic            out_prediction;

  hybrid_local_bimode_branch_predictor u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_action     (in_action),
    .in_pc         (in_pc),
    .in_outcome    (in_outcome),
    .out_valid     (out_valid),
    .out_prediction(out_prediction)
  );

  // Shadow copy of the predictor tables.
  logic [LH_W-1:0] lhist    [1 << PCI_W];
  logic [1:0]      lctr     [1 << LH_W];
  logic [GH_W-1:0] ghist;
  logic [1:0]      nt_bank  [1 << GH_W];
  logic [1:0]      tk_bank  [1 << GH_W];
  logic [1:0]      chooser  [1 << CH_W];
  logic [1:0]      selector [1 << GH_W];

  req_t branch_q[$];
  logic dir_q[$];
  req_t cur_word;
  logic drv_go;
  logic exp_dir;
  int   err_count   = 0;
  int   n_total     = 0;
  int   n_accepted  = 0;
  int   idle_left   = 0;
  int   cycle_count = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // Saturating 2-bit counter step.
  function automatic logic [1:0] sat_step(logic [1:0] c, logic up);
    if (up) begin
      return (c == 2'd3) ? c : c + 2'd1;
    end
    return (c == 2'd0) ? c : c - 2'd1;
  endfunction

  // Returns the direction the block should give for this word, then trains the
  // shadow tables if the word is a train request.
  function automatic logic resolve_branch(req_t w);
    logic [PCI_W-1:0] li;
    logic [LH_W-1:0]  ci;
    logic [GH_W-1:0]  gi;
    logic [CH_W-1:0]  hi;
    logic             loc_dir;
    logic             glob_dir;
    logic             use_tk;
    logic             use_loc;
    logic             dir;
    li       = w.pc[PCI_W-1:0];
    ci       = lhist[li];
    gi       = ghist ^ w.pc[GH_W-1:0];
    hi       = w.pc[CH_W-1:0];
    loc_dir  = lctr[ci] >= 2'd2;
    use_tk   = chooser[hi] >= 2'd2;
    glob_dir = use_tk ? (tk_bank[gi] >= 2'd2) : (nt_bank[gi] >= 2'd2);
    use_loc  = selector[gi] >= 2'd2;
    dir      = use_loc ? loc_dir : glob_dir;
    if (w.action == ACT_TRAIN) begin
      lctr[ci] = sat_step(lctr[ci], w.outcome);
      // The chooser holds still when the chosen bank was right against its bias.
      if (use_tk) begin
        tk_bank[gi] = sat_step(tk_bank[gi], w.outcome);
        if (!(glob_dir == w.outcome && glob_dir == NOT_TAKEN)) begin
          chooser[hi] = sat_step(chooser[hi], w.outcome);
        end
      end else begin
        nt_bank[gi] = sat_step(nt_bank[gi], w.outcome);
        if (!(glob_dir == w.outcome && glob_dir == TAKEN)) begin
          chooser[hi] = sat_step(chooser[hi], w.outcome);
        end
      end
      // The selector moves only when exactly one side was right.
      if (loc_dir == w.outcome && glob_dir != w.outcome) begin
        selector[gi] = sat_step(selector[gi], 1'b1);
      end else if (loc_dir != w.outcome && glob_dir == w.outcome) begin
        selector[gi] = sat_step(selector[gi], 1'b0);
      end
      lhist[li] = {lhist[li][LH_W-2:0], w.outcome};
      ghist     = {ghist[GH_W-2:0], w.outcome};
    end
    return dir;
  endfunction

  task automatic add_branch(logic act, logic [PC_W-1:0] pc, logic oc);
    req_t w;
    w.action  = act;
    w.pc      = pc;
    w.outcome = oc;
    branch_q.push_back(w);
  endtask

  // Driver: presents one word at a time and records the expected direction at
  // the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy) begin
        dir_q.push_back(resolve_branch(cur_word));
        n_accepted++;
      end
      if (!start || !busy) begin
        drv_go = 1'b0;
        if (idle_left > 0) begin
          idle_left--;
        end else if (branch_q.size() != 0) begin
          // Idle bursts are left out of every third stretch and of the tail.
          if (n_accepted < n_total - CALM_TAIL && (n_accepted / 64) % 3 != 2 &&
              $urandom_range(0, 4) == 0) begin
            idle_left = $urandom_range(0, 2);
          end else begin
            cur_word = branch_q.pop_front();
            drv_go   = 1'b1;
          end
        end
        start <= drv_go;
        if (drv_go) begin
          in_action  <= cur_word.action;
          in_pc      <= cur_word.pc;
          in_outcome <= cur_word.outcome;
        end
      end
    end
  end

  // Monitor: every strobed word is checked against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      if (dir_q.size() == 0) begin
        $error("unexpected word: prediction %0d with nothing pending", out_prediction);
        err_count++;
      end else begin
        exp_dir = dir_q.pop_front();
        if (out_prediction !== exp_dir) begin
          $error("prediction mismatch: expected %0d, actual %0d", exp_dir, out_prediction);
          err_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    logic [PC_W-1:0] hot_pc  [16];
    logic [PC_W-1:0] loop_pc [6];
    int              period  [6];
    logic [7:0]      pattern [6];
    int              nloop;
    int              iters;
    logic            act;

    // Shadow tables start in their reset states.
    foreach (lhist[i]) lhist[i] = '0;
    foreach (lctr[i]) lctr[i] = WN;
    foreach (nt_bank[i]) nt_bank[i] = WN;
    foreach (tk_bank[i]) tk_bank[i] = WT;
    foreach (chooser[i]) chooser[i] = WNG;
    foreach (selector[i]) selector[i] = WG;
    ghist = '0;

    // Directed words: pc extremes, predict with the outcome ignored, counters
    // driven to saturation both ways, and aliasing through unused pc bits.
    add_branch(ACT_PREDICT, 32'h0000_0000, TAKEN);
    add_branch(ACT_PREDICT, 32'hFFFF_FFFF, NOT_TAKEN);
    add_branch(ACT_PREDICT, 32'hFFFF_FFFF, TAKEN);
    add_branch(ACT_TRAIN, 32'h0000_0000, TAKEN);
    add_branch(ACT_TRAIN, 32'hFFFF_FFFF, NOT_TAKEN);
    repeat (5) add_branch(ACT_TRAIN, 32'h1234_5678, TAKEN);
    add_branch(ACT_PREDICT, 32'h1234_5678, NOT_TAKEN);
    repeat (5) add_branch(ACT_TRAIN, 32'h1234_5678, NOT_TAKEN);
    add_branch(ACT_PREDICT, 32'hFFFF_F678, TAKEN);
    add_branch(ACT_TRAIN, 32'hFFFF_F678, TAKEN);
    add_branch(ACT_TRAIN, 32'h8000_0000, TAKEN);
    add_branch(ACT_TRAIN, 32'h7FFF_FFFF, NOT_TAKEN);
    add_branch(ACT_PREDICT, 32'h1234_5678, TAKEN);

    // A small set of hot branches; the last four alias the first four in the
    // low index bits but differ above them.
    for (int i = 0; i < 16; i++) begin
      hot_pc[i] = $urandom;
      if (i >= 12) hot_pc[i][CH_W-1:0] = hot_pc[i - 12][CH_W-1:0];
    end

    // Random part: mostly loops of hot branches with periodic outcomes, so the
    // histories learn real patterns, plus bursts of fully random words.
    while (branch_q.size() < 25 + RANDOM_WORDS) begin
      if ($urandom_range(0, 4) == 0) begin
        repeat ($urandom_range(1, 8)) begin
          add_branch(1'($urandom_range(0, 1)), $urandom, 1'($urandom_range(0, 1)));
        end
      end else begin
        nloop = $urandom_range(1, 6);
        iters = $urandom_range(4, 20);
        for (int j = 0; j < nloop; j++) begin
          loop_pc[j] = hot_pc[$urandom_range(0, 15)];
          period[j]  = $urandom_range(1, 8);
          pattern[j] = 8'($urandom);
        end
        for (int r = 0; r < iters; r++) begin
          for (int j = 0; j < nloop; j++) begin
            act = ($urandom_range(0, 7) == 0) ? ACT_PREDICT : ACT_TRAIN;
            add_branch(act, loop_pc[j], pattern[j][r % period[j]]);
          end
        end
      end
    end
    n_total = branch_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every word to be taken and every prediction to come back.
    while (branch_q.size() != 0 || start || dir_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_count == 0 && dir_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
